/* rtl/rfls_pkg.sv */
// rfls_pkg: shared constants, frame record type and luma helper functions
// for the rgb565 frame luma statistics block; no dependencies
`timescale 1ns / 1ps

package rfls_pkg;

	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned PixW     = 16;
	localparam int unsigned LumaW    = 8;
	localparam int unsigned SumW     = 40;
	localparam int unsigned CntW     = 32;
	localparam int unsigned TotalW   = 32;
	localparam int unsigned QuoStepW = 3;

	localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [CfgDataW-1:0] SIZE_MIN     = 16'd2;
	localparam logic [CfgDataW-1:0] WIDTH_RESET  = 16'd320;
	localparam logic [CfgDataW-1:0] HEIGHT_RESET = 16'd240;
	localparam logic [LumaW-1:0]    LUMA_MIN_RESET = 8'd255;
	localparam logic [LumaW-1:0]    LUMA_MAX_RESET = 8'd0;

	typedef struct packed {
		logic [LumaW-1:0] min_luma;
		logic [LumaW-1:0] max_luma;
		logic [SumW-1:0]  sum;
		logic [CntW-1:0]  count;
	} frame_rec_t;

	// floor(c*255/31) by reciprocal multiply, exact for 5-bit c
	function automatic logic [LumaW-1:0] expand5(input logic [4:0] c);
		logic [26:0] p;
		p = 27'(c) * 27'd255 * 27'd8457;
		return p[25:18];
	endfunction

	// floor(c*255/63) by reciprocal multiply, exact for 6-bit c
	function automatic logic [LumaW-1:0] expand6(input logic [5:0] c);
		logic [28:0] p;
		p = 29'(c) * 29'd255 * 29'd16645;
		return p[27:20];
	endfunction

	// floor(s/3) for s up to 765
	function automatic logic [LumaW-1:0] div3(input logic [9:0] s);
		logic [19:0] p;
		p = 20'(s) * 20'd683;
		return p[18:11];
	endfunction

endpackage

/* rtl/rgb565_frame_luma_stats.sv */
// rgb565_frame_luma_stats: one pixel per cycle; a frame's last pixel passes the
// expansion and luma registers into the record queue, the divider then loads it
// and works out the mean bit by bit, after which the result shows.
// Pixels stall only when the record queue and pipeline together fill up.
// Reset: size registers to 320 x 240, frame state cleared, no result waiting.
`timescale 1ns / 1ps

module rgb565_frame_luma_stats #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rfls_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [rfls_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic [rfls_pkg::PixW-1:0]     pixel_value,
	output logic                          empty,
	input  logic                          pop,
	output logic [rfls_pkg::LumaW-1:0]    frame_min_luma,
	output logic [rfls_pkg::LumaW-1:0]    frame_max_luma,
	output logic [rfls_pkg::LumaW-1:0]    frame_avg_luma
);

	localparam int unsigned LvlW = $clog2(QUEUE_DEPTH + 1);

	rfls_pkg::frame_rec_t rec_in, rec_out;
	logic                 rec_push, rec_pop, rec_valid;
	logic [LvlW-1:0]      level;

	rfls_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.pixel_value (pixel_value),
		.full        (full),
		.level       (level),
		.rec_push    (rec_push),
		.rec         (rec_in)
	);

	rfls_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (rec_push),
		.wr_data  (rec_in),
		.rd_en    (rec_pop),
		.rd_data  (rec_out),
		.nonempty (rec_valid),
		.level    (level)
	);

	rfls_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_valid      (rec_valid),
		.rec            (rec_out),
		.rec_pop        (rec_pop),
		.empty          (empty),
		.pop            (pop),
		.frame_min_luma (frame_min_luma),
		.frame_max_luma (frame_max_luma),
		.frame_avg_luma (frame_avg_luma)
	);

endmodule

/* rtl/rfls_front.sv */
// rfls_front: size registers, luma pipeline and per-frame min/max/sum accumulation
// depends on rfls_pkg
`timescale 1ns / 1ps

module rfls_front #(
	parameter int unsigned DEPTH = 4,
	localparam int unsigned LvlW = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rfls_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [rfls_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          push,
	input  logic [rfls_pkg::PixW-1:0]     pixel_value,
	output logic                          full,
	input  logic [LvlW-1:0]               level,
	output logic                          rec_push,
	output rfls_pkg::frame_rec_t          rec
);

	logic [rfls_pkg::CfgDataW-1:0] width_q, height_q, size_clamped;
	logic [rfls_pkg::TotalW-1:0]   total_q;
	logic                          v_s1, v_s2;
	logic [rfls_pkg::LumaW-1:0]    r8_s1, g8_s1, b8_s1, luma_s2;
	logic [rfls_pkg::CntW-1:0]     pix_q, cnt_nxt;
	logic [rfls_pkg::LumaW-1:0]    min_q, max_q, min_nxt, max_nxt;
	logic [rfls_pkg::SumW-1:0]     sum_q, sum_nxt;
	logic [LvlW+1:0]               occupancy;
	logic                          accept, frame_end;

	// count records in flight so a frame end always finds a free slot
	assign occupancy = (LvlW+2)'(level) + (LvlW+2)'(v_s1) + (LvlW+2)'(v_s2);
	assign full      = occupancy >= (LvlW+2)'(DEPTH);
	assign accept    = push & ~full;

	assign size_clamped = (cfg_data < rfls_pkg::SIZE_MIN) ? rfls_pkg::SIZE_MIN : cfg_data;

	assign cnt_nxt   = pix_q + 1'b1;
	assign sum_nxt   = sum_q + rfls_pkg::SumW'(luma_s2);
	assign min_nxt   = (luma_s2 < min_q) ? luma_s2 : min_q;
	assign max_nxt   = (luma_s2 > max_q) ? luma_s2 : max_q;
	assign frame_end = cnt_nxt >= total_q;

	assign rec_push     = v_s2 & frame_end;
	assign rec.min_luma = min_nxt;
	assign rec.max_luma = max_nxt;
	assign rec.sum      = sum_nxt;
	assign rec.count    = cnt_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rfls_pkg::WIDTH_RESET;
			height_q <= rfls_pkg::HEIGHT_RESET;
			total_q  <= rfls_pkg::TotalW'(rfls_pkg::WIDTH_RESET) *
				rfls_pkg::TotalW'(rfls_pkg::HEIGHT_RESET);
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			pix_q    <= '0;
			min_q    <= rfls_pkg::LUMA_MIN_RESET;
			max_q    <= rfls_pkg::LUMA_MAX_RESET;
			sum_q    <= '0;
		end else begin
			if (cfg_we && cfg_index == rfls_pkg::REG_FRAME_WIDTH) begin
				width_q <= size_clamped;
			end
			if (cfg_we && cfg_index == rfls_pkg::REG_FRAME_HEIGHT) begin
				height_q <= size_clamped;
			end
			total_q <= rfls_pkg::TotalW'(width_q) * rfls_pkg::TotalW'(height_q);
			v_s1    <= accept;
			v_s2    <= v_s1;
			if (v_s2) begin
				if (frame_end) begin
					pix_q <= '0;
					min_q <= rfls_pkg::LUMA_MIN_RESET;
					max_q <= rfls_pkg::LUMA_MAX_RESET;
					sum_q <= '0;
				end else begin
					pix_q <= cnt_nxt;
					min_q <= min_nxt;
					max_q <= max_nxt;
					sum_q <= sum_nxt;
				end
			end
		end
	end

	// channel expansion, then luma
	always_ff @(posedge clk) begin
		if (accept) begin
			r8_s1 <= rfls_pkg::expand5(pixel_value[15:11]);
			g8_s1 <= rfls_pkg::expand6(pixel_value[10:5]);
			b8_s1 <= rfls_pkg::expand5(pixel_value[4:0]);
		end
		if (v_s1) begin
			luma_s2 <= rfls_pkg::div3(10'(r8_s1) + 10'(g8_s1) + 10'(b8_s1));
		end
	end

endmodule

/* rtl/rfls_queue.sv */
// rfls_queue: small register queue of finished frame records
// depends on rfls_pkg
`timescale 1ns / 1ps

module rfls_queue #(
	parameter int unsigned DEPTH = 4,
	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned LvlW = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  rfls_pkg::frame_rec_t wr_data,
	input  logic                 rd_en,
	output rfls_pkg::frame_rec_t rd_data,
	output logic                 nonempty,
	output logic [LvlW-1:0]      level
);

	rfls_pkg::frame_rec_t entries [DEPTH];
	logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [LvlW-1:0]      level_q;

	assign rd_data  = entries[rd_ptr_q];
	assign nonempty = level_q != '0;
	assign level    = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				level_q <= level_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* rtl/rfls_back.sv */
// rfls_back: bit-serial mean division and result register
// depends on rfls_pkg
`timescale 1ns / 1ps

module rfls_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rec_valid,
	input  rfls_pkg::frame_rec_t       rec,
	output logic                       rec_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic [rfls_pkg::LumaW-1:0] frame_min_luma,
	output logic [rfls_pkg::LumaW-1:0] frame_max_luma,
	output logic [rfls_pkg::LumaW-1:0] frame_avg_luma
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_HOLD} state_t;

	state_t                        state_q;
	logic [rfls_pkg::SumW-1:0]     rem_q, dsr_q;
	logic [rfls_pkg::LumaW-1:0]    quo_q, min_q, max_q;
	logic [rfls_pkg::QuoStepW-1:0] step_q;
	logic                          ge;

	assign ge      = rem_q >= dsr_q;
	assign rec_pop = (state_q == ST_IDLE) && rec_valid;
	assign empty   = state_q != ST_HOLD;

	assign frame_min_luma = min_q;
	assign frame_max_luma = max_q;
	assign frame_avg_luma = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			rem_q   <= '0;
			dsr_q   <= '0;
			quo_q   <= '0;
			min_q   <= '0;
			max_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (rec_valid) begin
						// quotient fits 8 bits, so start at divisor << 7
						rem_q   <= rec.sum;
						dsr_q   <= {1'b0, rec.count, 7'b0};
						quo_q   <= '0;
						min_q   <= rec.min_luma;
						max_q   <= rec.max_luma;
						step_q  <= '1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (ge) begin
						rem_q <= rem_q - dsr_q;
					end
					dsr_q  <= dsr_q >> 1;
					quo_q  <= {quo_q[rfls_pkg::LumaW-2:0], ge};
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (pop) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* sim/rfls_luma_compare.sv */
// rfls_luma_compare: watches the size-register writes, the pixel transfers and the
// frame-result transfers of rgb565_frame_luma_stats, predicts each frame result and
// compares it field by field; depends on rfls_pkg
`timescale 1ns / 1ps

module rfls_luma_compare (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rfls_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [rfls_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          push,
	input  logic                          full,
	input  logic [rfls_pkg::PixW-1:0]     pixel_value,
	input  logic                          empty,
	input  logic                          pop,
	input  logic [rfls_pkg::LumaW-1:0]    frame_min_luma,
	input  logic [rfls_pkg::LumaW-1:0]    frame_max_luma,
	input  logic [rfls_pkg::LumaW-1:0]    frame_avg_luma,
	output int                            mismatches,
	output int                            pending,
	output int                            frame_fill,
	output int                            pixels_in,
	output int                            frames_done
);

	import rfls_pkg::*;

	typedef struct packed {
		logic [LumaW-1:0] lo;
		logic [LumaW-1:0] hi;
		logic [LumaW-1:0] mean;
	} frame_stats_t;

	frame_stats_t      expected_frames[$];
	logic [CfgDataW-1:0] width_r;
	logic [CfgDataW-1:0] height_r;
	logic [CntW-1:0]   fill_cnt;
	logic [LumaW-1:0]  run_lo;
	logic [LumaW-1:0]  run_hi;
	logic [SumW-1:0]   run_sum;

	function automatic logic [LumaW-1:0] pixel_luma8(input logic [PixW-1:0] px);
		int unsigned red;
		int unsigned green;
		int unsigned blue;
		red   = px[15:11];
		green = px[10:5];
		blue  = px[4:0];
		red   = red * 255 / 31;
		green = green * 255 / 63;
		blue  = blue * 255 / 31;
		return LumaW'((red + green + blue) / 3);
	endfunction

	function automatic logic [CfgDataW-1:0] clamp_size(input logic [CfgDataW-1:0] v);
		return (v < SIZE_MIN) ? SIZE_MIN : v;
	endfunction

	task automatic report(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic clear_frame();
		fill_cnt = '0;
		run_lo   = LUMA_MIN_RESET;
		run_hi   = LUMA_MAX_RESET;
		run_sum  = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_stats_t got;
		frame_stats_t want;
		logic [LumaW-1:0] lum;
		logic [63:0] total;
		if (!arst_n) begin
			width_r  = WIDTH_RESET;
			height_r = HEIGHT_RESET;
			clear_frame();
			expected_frames.delete();
			mismatches  = 0;
			pixels_in   = 0;
			frames_done = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  width_r = clamp_size(cfg_data);
					REG_FRAME_HEIGHT: height_r = clamp_size(cfg_data);
					default: ;
				endcase
			end
			if (push && !full) begin
				lum = pixel_luma8(pixel_value);
				if (lum < run_lo)
					run_lo = lum;
				if (lum > run_hi)
					run_hi = lum;
				run_sum  = run_sum + SumW'(lum);
				fill_cnt = fill_cnt + 1'b1;
				pixels_in++;
				total = 64'(width_r) * 64'(height_r);
				if (64'(fill_cnt) >= total) begin
					want.lo   = run_lo;
					want.hi   = run_hi;
					want.mean = LumaW'(run_sum / SumW'(fill_cnt));
					expected_frames.push_back(want);
					clear_frame();
				end
			end
			if (pop && !empty) begin
				got = {frame_min_luma, frame_max_luma, frame_avg_luma};
				if (expected_frames.size() == 0) begin
					report($sformatf("result transfer with no frame pending: min %0d max %0d avg %0d",
						got.lo, got.hi, got.mean));
				end else begin
					want = expected_frames.pop_front();
					frames_done++;
					if (got.lo != want.lo)
						report($sformatf("frame %0d min luma %0d, expected %0d",
							frames_done, got.lo, want.lo));
					if (got.hi != want.hi)
						report($sformatf("frame %0d max luma %0d, expected %0d",
							frames_done, got.hi, want.hi));
					if (got.mean != want.mean)
						report($sformatf("frame %0d mean luma %0d, expected %0d",
							frames_done, got.mean, want.mean));
				end
			end
		end
		pending    = expected_frames.size();
		frame_fill = int'(fill_cnt);
	end

endmodule

/* sim/rgb565_frame_luma_stats_tb.sv */
// rgb565_frame_luma_stats_tb: drives pixels, size writes and result pops with random
// stalls into rgb565_frame_luma_stats; rfls_luma_compare does the checking
// depends on rfls_pkg, rgb565_frame_luma_stats and rfls_luma_compare
`timescale 1ns / 1ps

module rgb565_frame_luma_stats_tb;

	import rfls_pkg::*;

	localparam logic [CfgIdxW-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_SPARE_B = 2'd3;
	localparam int PIXEL_TARGET  = 1400;
	localparam int CALM_FROM     = 1250;
	localparam int SETTLE_CYCLES = 24;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                push;
	logic                full;
	logic [PixW-1:0]     pixel_value;
	logic                empty;
	logic                pop;
	logic [LumaW-1:0]    frame_min_luma;
	logic [LumaW-1:0]    frame_max_luma;
	logic [LumaW-1:0]    frame_avg_luma;
	logic                calm;

	int mismatches;
	int pending;
	int frame_fill;
	int pixels_in;
	int frames_done;
	int size_writes;

	rgb565_frame_luma_stats i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.pixel_value    (pixel_value),
		.empty          (empty),
		.pop            (pop),
		.frame_min_luma (frame_min_luma),
		.frame_max_luma (frame_max_luma),
		.frame_avg_luma (frame_avg_luma)
	);

	rfls_luma_compare i_luma_compare (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.pixel_value    (pixel_value),
		.empty          (empty),
		.pop            (pop),
		.frame_min_luma (frame_min_luma),
		.frame_max_luma (frame_max_luma),
		.frame_avg_luma (frame_avg_luma),
		.mismatches     (mismatches),
		.pending        (pending),
		.frame_fill     (frame_fill),
		.pixels_in      (pixels_in),
		.frames_done    (frames_done)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("timeout with %0d frame results outstanding", pending);
		$display("rgb565_frame_luma_stats: mismatch");
		$finish;
	end

	// result side: random stall bursts until the calm part of the run
	initial begin
		int hold;
		hold = 0;
		pop  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				hold = $urandom_range(1, 17) - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic send_pixel(input logic [PixW-1:0] px);
		if (!calm && $urandom_range(0, 9) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		push        <= 1'b1;
		pixel_value <= px;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		size_writes++;
	endtask

	function automatic logic [PixW-1:0] pick_pixel();
		case ($urandom_range(0, 11))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return $urandom_range(0, 1) ? 16'h8410 : 16'h7BEF;
			3:       return 16'hF800 | PixW'($urandom_range(0, 16'h07FF));
			default: return PixW'($urandom);
		endcase
	endfunction

	initial begin
		int w;
		int h;
		int tot;
		int n;
		int k;
		bit flat;
		logic [PixW-1:0] flat_px;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		push        = 1'b0;
		pixel_value = '0;
		calm        = 1'b0;
		size_writes = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset size frame partly filled, then shrunk below its count
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		send_pixel(16'hF800);
		send_pixel(16'h07E0);
		send_pixel(16'h001F);
		settle();
		write_reg(REG_FRAME_WIDTH, 16'd0);
		write_reg(REG_FRAME_HEIGHT, 16'd1);
		send_pixel(16'h8410);
		settle();

		// smallest frames, flat white then flat black
		repeat (4) send_pixel(16'hFFFF);
		repeat (4) send_pixel(16'h0000);
		settle();

		// spare indexes leave the size alone
		write_reg(REG_SPARE_A, 16'h0000);
		write_reg(REG_SPARE_B, 16'hFFFF);
		send_pixel(16'h0821);
		send_pixel(16'hF7DE);
		send_pixel(16'h001F);
		send_pixel(16'hF800);
		settle();

		// largest size, then a size change mid-frame that the count reaches
		write_reg(REG_FRAME_WIDTH, 16'hFFFF);
		write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		send_pixel(16'h7BEF);
		settle();
		write_reg(REG_FRAME_WIDTH, 16'd3);
		write_reg(REG_FRAME_HEIGHT, 16'd2);
		send_pixel(16'h0001);
		send_pixel(16'h0020);
		send_pixel(16'h0800);
		settle();

		while (pixels_in < PIXEL_TARGET) begin
			if (pixels_in >= CALM_FROM)
				calm <= 1'b1;
			case ($urandom_range(0, 15))
				0: begin
					w = $urandom_range(0, 1);
					h = $urandom_range(2, 4);
				end
				1: begin
					w = $urandom_range(2, 4);
					h = $urandom_range(0, 1);
				end
				2, 3: begin
					w = $urandom_range(7, 40);
					h = $urandom_range(2, 3);
				end
				default: begin
					w = $urandom_range(2, 6);
					h = $urandom_range(2, 5);
				end
			endcase
			if ($urandom_range(0, 5) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CfgDataW'($urandom));
			if ($urandom_range(0, 1)) begin
				write_reg(REG_FRAME_WIDTH, CfgDataW'(w));
				write_reg(REG_FRAME_HEIGHT, CfgDataW'(h));
			end else begin
				write_reg(REG_FRAME_HEIGHT, CfgDataW'(h));
				write_reg(REG_FRAME_WIDTH, CfgDataW'(w));
			end
			tot = (w < 2 ? 2 : w) * (h < 2 ? 2 : h);
			if ($urandom_range(0, 4) != 0) begin
				k = $urandom_range(1, 3);
				n = (frame_fill >= tot) ? 1 + tot * (k - 1) : tot * k - frame_fill;
			end else begin
				n = $urandom_range(1, tot + 3);
			end
			flat    = ($urandom_range(0, 7) == 0);
			flat_px = PixW'($urandom);
			repeat (n) send_pixel(flat ? flat_px : pick_pixel());
			settle();
		end

		calm <= 1'b1;
		settle();
		$display("run covered %0d pixel transfers, %0d frame results and %0d register writes",
			pixels_in, frames_done, size_writes);
		if (mismatches == 0 && pending == 0) begin
			$display("rgb565_frame_luma_stats: match");
		end else begin
			$display("rgb565_frame_luma_stats: mismatch");
		end
		$finish;
	end

endmodule

/* rgb565_frame_luma_stats.f */
rtl/rfls_pkg.sv
rtl/rfls_front.sv
rtl/rfls_queue.sv
rtl/rfls_back.sv
rtl/rgb565_frame_luma_stats.sv
sim/rfls_luma_compare.sv
sim/rgb565_frame_luma_stats_tb.sv
